// ===== src/nvwt_pkg.sv =====
// ----------------------------------------------------------------------------
// nvwt_pkg
// Shared types and constants for the nearest-vertex weight transfer unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nvwt_pkg;

  localparam int POS_W    = 24;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * POS_W + 1;   // |d| <= 2^24, so d*d fits 49 bits
  localparam int DIST_W   = SQ_W + 1;        // sum of three squares
  localparam int WEIGHT_W = 16;
  localparam int JOINT_W  = 8;
  localparam int MATCH_W  = 10;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pos_t;

  typedef struct packed {
    logic [JOINT_W-1:0]  j2;
    logic [JOINT_W-1:0]  j1;
    logic [JOINT_W-1:0]  j0;
    logic [WEIGHT_W-1:0] w2;
    logic [WEIGHT_W-1:0] w1;
    logic [WEIGHT_W-1:0] w0;
  } skin_t;

endpackage

// ===== src/nvwt_ram.sv =====
// ----------------------------------------------------------------------------
// nvwt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nvwt_ram #(
  parameter int DATA_W = 72,
  parameter int DEPTH  = 1024,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/nvwt_dist.sv =====
// ----------------------------------------------------------------------------
// nvwt_dist
// Three-stage squared Euclidean distance pipe: difference, square, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nvwt_dist #(
  parameter int IDX_W = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [IDX_W-1:0]            in_idx,
  input  nvwt_pkg::pos_t              stored,
  input  nvwt_pkg::pos_t              query,
  output logic                        d_vld,
  output logic [IDX_W-1:0]            d_idx,
  output logic [nvwt_pkg::DIST_W-1:0] d_sum
);

  logic                               s1_vld, s2_vld;
  logic [IDX_W-1:0]                   s1_idx, s2_idx;
  logic signed [nvwt_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [nvwt_pkg::SQ_W-1:0]          sx, sy, sz;
  logic signed [2*nvwt_pkg::DIFF_W-1:0] px, py, pz;

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      d_vld  <= 1'b0;
    end else begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
      d_vld  <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= in_idx;
    dx <= nvwt_pkg::DIFF_W'(stored.x) - nvwt_pkg::DIFF_W'(query.x);
    dy <= nvwt_pkg::DIFF_W'(stored.y) - nvwt_pkg::DIFF_W'(query.y);
    dz <= nvwt_pkg::DIFF_W'(stored.z) - nvwt_pkg::DIFF_W'(query.z);
    s2_idx <= s1_idx;
    sx <= px[nvwt_pkg::SQ_W-1:0];
    sy <= py[nvwt_pkg::SQ_W-1:0];
    sz <= pz[nvwt_pkg::SQ_W-1:0];
    d_idx <= s2_idx;
    d_sum <= nvwt_pkg::DIST_W'(sx) + nvwt_pkg::DIST_W'(sy) + nvwt_pkg::DIST_W'(sz);
  end

endmodule

// ===== src/nearest_vertex_weight_transfer_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_vertex_weight_transfer_unit
// Skin-weight transfer by brute-force nearest stored vertex.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries func, a position, three weights
//   and three joints. func load appends an entry (dropped when the table is
//   full), clear empties the table, query produces one result beat on the
//   output channel (out_valid/out_ready); other codes are consumed silently.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the custom-weights
//   mode bit; write it only while the block is idle.
// Flow:
//   Load, clear and unused codes leave the block idle, ready for the next item.
//   A query with custom weights on, or on an empty table, goes straight to
//   the finish state. A search query reads the position RAM one entry per
//   cycle, the distance pipe and best-so-far compare drain behind it, then
//   the winning entry's weights are read from the second RAM in the fetch
//   state before the finish state. The finish state moves the result into
//   the output register once it is free, and the block is then ready for
//   the next item, even if the result is not yet taken.
// Reset clears the entry count and the config register; RAM contents are not
//   cleared. A stalled receiver holds the result and the block stops at the
//   end of the next query until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_vertex_weight_transfer_unit #(
  parameter int MAX_OLD_VERTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nvwt_pkg::FUNC_W-1:0]     func,
  input  logic signed [nvwt_pkg::POS_W-1:0] pos_x,
  input  logic signed [nvwt_pkg::POS_W-1:0] pos_y,
  input  logic signed [nvwt_pkg::POS_W-1:0] pos_z,
  input  logic [nvwt_pkg::WEIGHT_W-1:0]   in_weight_0,
  input  logic [nvwt_pkg::WEIGHT_W-1:0]   in_weight_1,
  input  logic [nvwt_pkg::WEIGHT_W-1:0]   in_weight_2,
  input  logic [nvwt_pkg::JOINT_W-1:0]    in_joint_0,
  input  logic [nvwt_pkg::JOINT_W-1:0]    in_joint_1,
  input  logic [nvwt_pkg::JOINT_W-1:0]    in_joint_2,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nvwt_pkg::WEIGHT_W-1:0]   out_weight_0,
  output logic [nvwt_pkg::WEIGHT_W-1:0]   out_weight_1,
  output logic [nvwt_pkg::WEIGHT_W-1:0]   out_weight_2,
  output logic [nvwt_pkg::JOINT_W-1:0]    out_joint_0,
  output logic [nvwt_pkg::JOINT_W-1:0]    out_joint_1,
  output logic [nvwt_pkg::JOINT_W-1:0]    out_joint_2,
  output logic [nvwt_pkg::MATCH_W-1:0]    match_index,
  output logic                            table_empty
);

  localparam int IDX_W  = (MAX_OLD_VERTS > 1) ? $clog2(MAX_OLD_VERTS) : 1;
  localparam int CNT_W  = $clog2(MAX_OLD_VERTS + 1);
  localparam int WIDE_W = (IDX_W > nvwt_pkg::MATCH_W) ? IDX_W : nvwt_pkg::MATCH_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FETCH  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [1:0] SRC_TABLE  = 2'd0;
  localparam logic [1:0] SRC_CUSTOM = 2'd1;
  localparam logic [1:0] SRC_EMPTY  = 2'd2;

  logic [1:0]                     state;
  logic [1:0]                     res_src;
  logic                           custom_on;
  logic [CNT_W-1:0]               entry_count;
  logic [CNT_W-1:0]               iss_cnt;
  logic                           rd_vld;
  logic [IDX_W-1:0]               rd_idx;
  nvwt_pkg::pos_t                 q_pos;
  nvwt_pkg::skin_t                q_skin;
  logic [nvwt_pkg::DIST_W-1:0]    best_d;
  logic [IDX_W-1:0]               win_idx;

  nvwt_pkg::pos_t                 in_pos, pos_rd;
  nvwt_pkg::skin_t                in_skin, skin_rd, res_skin;
  logic                           in_acc, full, do_load, issue, d_last, better, out_load;
  logic                           d_vld;
  logic [IDX_W-1:0]               d_idx;
  logic [nvwt_pkg::DIST_W-1:0]    d_sum;
  logic [WIDE_W-1:0]              best_wide;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (entry_count == CNT_W'(MAX_OLD_VERTS));
  assign do_load   = in_acc && (func == nvwt_pkg::FUNC_LOAD) && !full;
  assign issue     = (state == ST_SCAN) && (iss_cnt != entry_count);

  assign in_pos  = '{x: pos_x, y: pos_y, z: pos_z};
  assign in_skin = '{w0: in_weight_0, w1: in_weight_1, w2: in_weight_2,
                     j0: in_joint_0, j1: in_joint_1, j2: in_joint_2};

  nvwt_ram #(
    .DATA_W ($bits(nvwt_pkg::pos_t)),
    .DEPTH  (MAX_OLD_VERTS)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (in_pos),
    .rd_en   (issue),
    .rd_addr (iss_cnt[IDX_W-1:0]),
    .rd_data (pos_rd)
  );

  nvwt_ram #(
    .DATA_W ($bits(nvwt_pkg::skin_t)),
    .DEPTH  (MAX_OLD_VERTS)
  ) u_skin_ram (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (in_skin),
    .rd_en   (state == ST_FETCH),
    .rd_addr (win_idx),
    .rd_data (skin_rd)
  );

  nvwt_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .in_vld (rd_vld),
    .in_idx (rd_idx),
    .stored (pos_rd),
    .query  (q_pos),
    .d_vld  (d_vld),
    .d_idx  (d_idx),
    .d_sum  (d_sum)
  );

  // entry 0 always seeds the best; strict less-than keeps the lowest index on ties
  assign better   = (d_idx == '0) || (d_sum < best_d);
  assign d_last   = d_vld && (CNT_W'(d_idx) == entry_count - CNT_W'(1));
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  always_comb begin
    unique case (res_src)
      SRC_TABLE:  res_skin = skin_rd;
      SRC_CUSTOM: res_skin = q_skin;
      default:    res_skin = '0;
    endcase
  end

  assign best_wide = WIDE_W'(win_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      custom_on   <= 1'b0;
      entry_count <= '0;
      iss_cnt     <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cfg_valid && cfg_ready) begin
        custom_on <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        iss_cnt <= iss_cnt + CNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (func)
              nvwt_pkg::FUNC_LOAD: begin
                if (!full) begin
                  entry_count <= entry_count + CNT_W'(1);
                end
              end
              nvwt_pkg::FUNC_CLEAR: entry_count <= '0;
              nvwt_pkg::FUNC_QUERY: begin
                iss_cnt <= '0;
                if (custom_on || entry_count == '0) begin
                  state <= ST_FINISH;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (d_last) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH:  state <= ST_FINISH;
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // query latch, scan bookkeeping and output payload
  always_ff @(posedge clk) begin
    rd_idx <= iss_cnt[IDX_W-1:0];
    if (in_acc && func == nvwt_pkg::FUNC_QUERY) begin
      q_pos  <= in_pos;
      q_skin <= in_skin;
      if (custom_on) begin
        res_src <= SRC_CUSTOM;
      end else if (entry_count == '0) begin
        res_src <= SRC_EMPTY;
      end else begin
        res_src <= SRC_TABLE;
      end
    end
    if (state == ST_SCAN && d_vld && better) begin
      best_d  <= d_sum;
      win_idx <= d_idx;
    end
    if (out_load) begin
      out_weight_0 <= res_skin.w0;
      out_weight_1 <= res_skin.w1;
      out_weight_2 <= res_skin.w2;
      out_joint_0  <= res_skin.j0;
      out_joint_1  <= res_skin.j1;
      out_joint_2  <= res_skin.j2;
      match_index  <= (res_src == SRC_TABLE) ? best_wide[nvwt_pkg::MATCH_W-1:0] : '0;
      table_empty  <= (res_src == SRC_EMPTY);
    end
  end

endmodule

// ===== src/nvwt_checker.sv =====
// ----------------------------------------------------------------------------
// nvwt_checker
// Port-level checks for the nearest-vertex weight transfer unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nvwt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [nvwt_pkg::FUNC_W-1:0]   func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [nvwt_pkg::WEIGHT_W-1:0] out_weight_0,
  input logic [nvwt_pkg::WEIGHT_W-1:0] out_weight_1,
  input logic [nvwt_pkg::WEIGHT_W-1:0] out_weight_2,
  input logic [nvwt_pkg::MATCH_W-1:0]  match_index,
  input logic                          table_empty
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat visible right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_index))
    else $error("stalled result beat changed or dropped");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_empty |-> match_index == '0 && out_weight_0 == '0 &&
      out_weight_1 == '0 && out_weight_2 == '0)
    else $error("empty-table result carries nonzero fields");

  a_no_result_from_non_query: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func != nvwt_pkg::FUNC_QUERY |=> !$rose(out_valid))
    else $error("non-query beat produced a result");

endmodule

bind nearest_vertex_weight_transfer_unit nvwt_checker u_nvwt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .func         (func),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_weight_0 (out_weight_0),
  .out_weight_1 (out_weight_1),
  .out_weight_2 (out_weight_2),
  .match_index  (match_index),
  .table_empty  (table_empty)
);
